// File: rtl/vp8_rtp_packetizer_macros.svh
`ifndef VP8_RTP_PACKETIZER_MACROS_SVH
`define VP8_RTP_PACKETIZER_MACROS_SVH

`ifndef SYNTH

// same-cycle implication, disabled during reset
`define VP8RTP_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: implication check failed");

// next-cycle implication, disabled during reset
`define VP8RTP_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`else

`define VP8RTP_ASSERT_IMP(label, clk, rst, ante, cons)
`define VP8RTP_ASSERT_NXT(label, clk, rst, ante, cons)

`endif

`endif

// File: rtl/vp8rtp_pkg.sv
package vp8rtp_pkg;

  // register indexes on the configuration port
  typedef enum logic [2:0] {
    CFG_MAX_PAYLOAD    = 3'd0,
    CFG_TIMESTAMP_STEP = 3'd1,
    CFG_BUFFER_LIMIT   = 3'd2,
    CFG_PAYLOAD_TYPE   = 3'd3,
    CFG_SOURCE_ID      = 3'd4
  } cfg_idx_t;

  localparam logic [10:0] MAX_PAYLOAD_RESET    = 11'd1100;
  localparam logic [15:0] TIMESTAMP_STEP_RESET = 16'd3000;
  localparam logic [23:0] BUFFER_LIMIT_RESET   = 24'd5000000;
  localparam logic [6:0]  PAYLOAD_TYPE_RESET   = 7'd96;
  localparam logic [31:0] SOURCE_ID_RESET      = 32'd0;

  localparam logic [10:0] PAYLOAD_CAP    = 11'd1187;
  localparam logic [7:0]  RTP_VER_BYTE   = 8'h80;
  localparam logic [7:0]  DESC_FIRST     = 8'h10;
  localparam logic [7:0]  DESC_CONT      = 8'h00;
  localparam int          HEADER_LEN     = 13;

  // position of the byte on the output within one result run
  typedef enum logic [3:0] {
    POS_VER     = 4'd0,
    POS_PT      = 4'd1,
    POS_SEQ_HI  = 4'd2,
    POS_SEQ_LO  = 4'd3,
    POS_TS_3    = 4'd4,
    POS_TS_2    = 4'd5,
    POS_TS_1    = 4'd6,
    POS_TS_0    = 4'd7,
    POS_SSRC_3  = 4'd8,
    POS_SSRC_2  = 4'd9,
    POS_SSRC_1  = 4'd10,
    POS_SSRC_0  = 4'd11,
    POS_DESC    = 4'd12,
    POS_DATA    = 4'd13
  } pos_t;

  typedef struct packed {
    logic [10:0] max_payload;
    logic [15:0] timestamp_step;
    logic [23:0] buffer_limit;
    logic [6:0]  payload_type;
    logic [31:0] source_id;
  } cfg_t;

  // what the emitter needs for one payload byte, besides payload type and source id from cfg
  typedef struct packed {
    logic        has_hdr;
    logic [15:0] seq;
    logic [31:0] ts;
    logic        marker;
    logic        first;
    logic [7:0]  data;
    logic        pkt_end;
  } res_t;

endpackage

// File: rtl/vp8rtp_cfg.sv
module vp8rtp_cfg (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  logic [2:0]        wr_index,
  input  logic [31:0]       wr_data,
  output vp8rtp_pkg::cfg_t  cfg
);
  import vp8rtp_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_payload    <= MAX_PAYLOAD_RESET;
      cfg.timestamp_step <= TIMESTAMP_STEP_RESET;
      cfg.buffer_limit   <= BUFFER_LIMIT_RESET;
      cfg.payload_type   <= PAYLOAD_TYPE_RESET;
      cfg.source_id      <= SOURCE_ID_RESET;
    end else if (wr_en) begin
      unique case (wr_index)
        CFG_MAX_PAYLOAD:    cfg.max_payload    <= wr_data[10:0];
        CFG_TIMESTAMP_STEP: cfg.timestamp_step <= wr_data[15:0];
        CFG_BUFFER_LIMIT:   cfg.buffer_limit   <= wr_data[23:0];
        CFG_PAYLOAD_TYPE:   cfg.payload_type   <= wr_data[6:0];
        CFG_SOURCE_ID:      cfg.source_id      <= wr_data;
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/vp8rtp_ctrl.sv
module vp8rtp_ctrl #(
  parameter int MAX_FRAME_BYTES = 2097151
) (
  input  logic              clk,
  input  logic              rst,
  input  vp8rtp_pkg::cfg_t  cfg,
  input  logic              accept,
  input  logic              func,
  input  logic [20:0]       frame_bytes,
  input  logic signed [24:0] buffered_level,
  input  logic [7:0]        payload_byte,
  output logic              produce,
  output vp8rtp_pkg::res_t  res
);
  import vp8rtp_pkg::*;

  localparam int REM_W = $clog2(MAX_FRAME_BYTES + 1);
  localparam int CW    = (REM_W > 12) ? REM_W : 12;

  logic [15:0]      sequence_number, sequence_number_next;
  logic [31:0]      rtp_timestamp, rtp_timestamp_next;
  logic [REM_W-1:0] bytes_remaining, bytes_remaining_next;
  logic [10:0]      chunk_fill, chunk_fill_next;
  logic             frame_active, frame_active_next;
  logic             first_chunk, first_chunk_next;

  logic [10:0]      eff_max;
  logic [REM_W-1:0] len;
  logic             drop;
  logic [16:0]      ts_inc;
  logic [11:0]      fill_inc;
  logic [REM_W-1:0] rem_dec;
  logic             marker, pkt_end, last_byte;

  always_comb begin
    if (cfg.max_payload == 11'd0) eff_max = 11'd1;
    else if (cfg.max_payload > PAYLOAD_CAP) eff_max = PAYLOAD_CAP;
    else eff_max = cfg.max_payload;
  end

  // clamp oversized frames
  assign len = (32'(frame_bytes) > 32'(MAX_FRAME_BYTES)) ? REM_W'(MAX_FRAME_BYTES)
                                                          : REM_W'(frame_bytes);
  assign drop = buffered_level[24] || (buffered_level[23:0] > cfg.buffer_limit)
                || (len == '0);

  assign fill_inc  = {1'b0, chunk_fill} + 12'd1;
  assign rem_dec   = bytes_remaining - REM_W'(1);
  assign last_byte = (bytes_remaining == REM_W'(1));
  assign marker    = CW'(bytes_remaining) <= CW'(eff_max);
  assign pkt_end   = (fill_inc >= {1'b0, eff_max}) || last_byte;
  assign produce   = accept && func && frame_active;

  always_comb begin
    sequence_number_next = sequence_number;
    bytes_remaining_next = bytes_remaining;
    chunk_fill_next      = chunk_fill;
    frame_active_next    = frame_active;
    first_chunk_next     = first_chunk;
    ts_inc               = 17'd0;
    if (accept && !func) begin
      // abandoned frame and dropped frame each advance the timestamp
      case ({frame_active, drop}) inside
        2'b11:        ts_inc = {cfg.timestamp_step, 1'b0};
        2'b10, 2'b01: ts_inc = {1'b0, cfg.timestamp_step};
        default:      ts_inc = 17'd0;
      endcase
      frame_active_next    = !drop;
      chunk_fill_next      = '0;
      first_chunk_next     = 1'b1;
      bytes_remaining_next = drop ? '0 : len;
    end else if (produce) begin
      bytes_remaining_next = rem_dec;
      if (pkt_end) begin
        sequence_number_next = sequence_number + 16'd1;
        chunk_fill_next      = '0;
        first_chunk_next     = 1'b0;
        if (last_byte) begin
          frame_active_next = 1'b0;
          first_chunk_next  = 1'b1;
          ts_inc            = {1'b0, cfg.timestamp_step};
        end
      end else begin
        chunk_fill_next = fill_inc[10:0];
      end
    end
    rtp_timestamp_next = rtp_timestamp + 32'(ts_inc);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sequence_number <= '0;
      rtp_timestamp   <= '0;
      bytes_remaining <= '0;
      chunk_fill      <= '0;
      frame_active    <= 1'b0;
      first_chunk     <= 1'b1;
    end else begin
      sequence_number <= sequence_number_next;
      rtp_timestamp   <= rtp_timestamp_next;
      bytes_remaining <= bytes_remaining_next;
      chunk_fill      <= chunk_fill_next;
      frame_active    <= frame_active_next;
      first_chunk     <= first_chunk_next;
    end
  end

  assign res.has_hdr = (chunk_fill == '0);
  assign res.seq     = sequence_number;
  assign res.ts      = rtp_timestamp;
  assign res.marker  = marker;
  assign res.first   = first_chunk;
  assign res.data    = payload_byte;
  assign res.pkt_end = pkt_end;

endmodule

// File: rtl/vp8rtp_emit.sv
module vp8rtp_emit (
  input  logic              clk,
  input  logic              rst,
  input  vp8rtp_pkg::cfg_t  cfg,
  input  logic              load,
  input  vp8rtp_pkg::res_t  res_in,
  output logic              free,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_byte,
  output logic              is_header,
  output logic              packet_end,
  output logic              run_last
);
  import vp8rtp_pkg::*;

  res_t res;
  pos_t pos;
  logic busy;

  assign free = !busy || (out_ready && pos == POS_DATA);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pos  <= POS_DATA;
    end else if (load) begin
      busy <= 1'b1;
      pos  <= res_in.has_hdr ? POS_VER : POS_DATA;
    end else if (busy && out_ready) begin
      if (pos == POS_DATA) busy <= 1'b0;
      else pos <= pos_t'(pos + 4'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) res <= res_in;
  end

  always_comb begin
    unique case (pos)
      POS_VER:    out_byte = RTP_VER_BYTE;
      POS_PT:     out_byte = {res.marker, cfg.payload_type};
      POS_SEQ_HI: out_byte = res.seq[15:8];
      POS_SEQ_LO: out_byte = res.seq[7:0];
      POS_TS_3:   out_byte = res.ts[31:24];
      POS_TS_2:   out_byte = res.ts[23:16];
      POS_TS_1:   out_byte = res.ts[15:8];
      POS_TS_0:   out_byte = res.ts[7:0];
      POS_SSRC_3: out_byte = cfg.source_id[31:24];
      POS_SSRC_2: out_byte = cfg.source_id[23:16];
      POS_SSRC_1: out_byte = cfg.source_id[15:8];
      POS_SSRC_0: out_byte = cfg.source_id[7:0];
      POS_DESC:   out_byte = res.first ? DESC_FIRST : DESC_CONT;
      POS_DATA:   out_byte = res.data;
      default:    out_byte = res.data;
    endcase
  end

  assign out_valid  = busy;
  assign is_header  = (pos != POS_DATA);
  assign run_last   = (pos == POS_DATA);
  assign packet_end = (pos == POS_DATA) && res.pkt_end;

endmodule

// File: rtl/vp8_rtp_packetizer.sv
// vp8 rtp packetizer: turns a stream of frame-start and payload-byte items into a
// byte stream of rtp packets (13-byte header, then up to max_payload payload bytes).
// frame starts, ignored bytes and payload bytes that continue a chunk may arrive back
// to back; a payload byte that opens a chunk puts 14 bytes (header plus the byte)
// through the byte-wide output register and keeps in_ready low while its header is
// sent, so while out_ready holds the rate is one item per cycle within a chunk. an
// item is taken in the same cycle that the previous run's last byte is transferred.
// configuration writes are accepted in every cycle and must only be made while idle.
module vp8_rtp_packetizer #(
  parameter int MAX_FRAME_BYTES = 2097151
) (
  input  logic               clk,
  input  logic               rst,
  // configuration write channel
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  // input items
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               func,
  input  logic [20:0]        frame_bytes,
  input  logic signed [24:0] buffered_level,
  input  logic [7:0]         payload_byte,
  // result bytes
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_byte,
  output logic               is_header,
  output logic               packet_end,
  output logic               run_last
);
  import vp8rtp_pkg::*;

`include "vp8_rtp_packetizer_macros.svh"

  cfg_t cfg;
  res_t res;
  logic accept;
  logic produce;
  logic free;

  // register writes never stall
  assign cfg_ready = 1'b1;

  vp8rtp_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // an input transfer can happen whenever the output run is done or finishing
  assign in_ready = free;
  assign accept   = in_valid && in_ready;

  // frame and chunk state, updated at the input transfer
  vp8rtp_ctrl #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .accept         (accept),
    .func           (func),
    .frame_bytes    (frame_bytes),
    .buffered_level (buffered_level),
    .payload_byte   (payload_byte),
    .produce        (produce),
    .res            (res)
  );

  // header and payload serialiser behind the output register
  vp8rtp_emit u_emit (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .load       (produce),
    .res_in     (res),
    .free       (free),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte),
    .is_header  (is_header),
    .packet_end (packet_end),
    .run_last   (run_last)
  );

  // a new item only enters while the last byte of the previous run leaves
  `VP8RTP_ASSERT_IMP(a_ready_on_last, clk, rst, in_ready && out_valid, out_ready && run_last)
  // header bytes never close a packet
  `VP8RTP_ASSERT_IMP(a_end_is_payload, clk, rst, out_valid && packet_end, !is_header && run_last)
  // a header byte that is taken is always followed by more of the run
  `VP8RTP_ASSERT_NXT(a_header_runs_on, clk, rst, out_valid && out_ready && is_header, out_valid)

endmodule

// File: tb/vp8rtp_tb_pkg.sv
`timescale 1ns / 100ps

package vp8rtp_tb_pkg;

  // kind of item on the input channel, carried on func
  typedef enum logic {
    FRAME_OPEN   = 1'b0,
    PAYLOAD_BYTE = 1'b1
  } item_kind_t;

endpackage

// File: tb/vp8_rtp_stream_check.sv
`timescale 1ns / 100ps

module vp8_rtp_stream_check (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic               func,
  input  logic [20:0]        frame_bytes,
  input  logic signed [24:0] buffered_level,
  input  logic [7:0]         payload_byte,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [7:0]         out_byte,
  input  logic               is_header,
  input  logic               packet_end,
  input  logic               run_last,
  output int                 mismatches,
  output int                 owed
);
  import vp8rtp_pkg::*;
  import vp8rtp_tb_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       header;
    logic       pkt_last;
    logic       run_end;
  } stream_byte_t;

  stream_byte_t owed_bytes[$];
  int           mismatch_count = 0;

  logic [10:0] max_payload_r;
  logic [15:0] ts_step_r;
  logic [23:0] limit_r;
  logic [6:0]  pt_r;
  logic [31:0] ssrc_r;

  logic [15:0] seq_no;
  logic [31:0] rtp_ts;
  logic [20:0] bytes_left;
  logic [10:0] fill;
  logic        in_frame;
  logic        opening_chunk;

  function automatic logic [10:0] chunk_limit();
    if (max_payload_r == '0) return 11'd1;
    if (max_payload_r > PAYLOAD_CAP) return PAYLOAD_CAP;
    return max_payload_r;
  endfunction

  task automatic packetize(input item_kind_t kind, input logic [20:0] len,
                           input logic signed [24:0] lvl, input logic [7:0] data);
    logic [10:0]  cap;
    logic [103:0] hdr;
    logic         ends;
    int           i;
    cap = chunk_limit();
    if (kind == FRAME_OPEN) begin
      // an abandoned frame still moves the timestamp on
      if (in_frame) rtp_ts = rtp_ts + ts_step_r;
      in_frame      = 1'b0;
      fill          = '0;
      opening_chunk = 1'b1;
      bytes_left    = '0;
      if (lvl[24] || (lvl[23:0] > limit_r) || (len == '0)) begin
        rtp_ts = rtp_ts + ts_step_r;
      end else begin
        in_frame   = 1'b1;
        bytes_left = len;
      end
    end else if (in_frame) begin
      if (fill == '0) begin
        hdr = {RTP_VER_BYTE, (bytes_left <= cap), pt_r, seq_no, rtp_ts, ssrc_r,
               opening_chunk ? DESC_FIRST : DESC_CONT};
        for (i = HEADER_LEN - 1; i >= 0; i--) begin
          owed_bytes.push_back('{hdr[i*8 +: 8], 1'b1, 1'b0, 1'b0});
        end
      end
      fill       = fill + 11'd1;
      bytes_left = bytes_left - 21'd1;
      ends       = (fill >= cap) || (bytes_left == '0);
      owed_bytes.push_back('{data, 1'b0, ends, 1'b1});
      if (ends) begin
        seq_no        = seq_no + 16'd1;
        fill          = '0;
        opening_chunk = 1'b0;
        if (bytes_left == '0) begin
          in_frame      = 1'b0;
          opening_chunk = 1'b1;
          rtp_ts        = rtp_ts + ts_step_r;
        end
      end
    end
  endtask

  task automatic note_mismatch(input string field, input logic [7:0] want,
                               input logic [7:0] got);
    mismatch_count++;
    $display("%0t  %s mismatch: expected %h, actual %h", $time, field, want, got);
  endtask

  always @(posedge clk) begin : watch
    stream_byte_t want;
    if (rst) begin
      max_payload_r  = MAX_PAYLOAD_RESET;
      ts_step_r      = TIMESTAMP_STEP_RESET;
      limit_r        = BUFFER_LIMIT_RESET;
      pt_r           = PAYLOAD_TYPE_RESET;
      ssrc_r         = SOURCE_ID_RESET;
      seq_no         = '0;
      rtp_ts         = '0;
      bytes_left     = '0;
      fill           = '0;
      in_frame       = 1'b0;
      opening_chunk  = 1'b1;
      mismatch_count = 0;
      owed_bytes.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (owed_bytes.size() == 0) begin
          mismatch_count++;
          $display("%0t  stray out_byte: expected none, actual %h", $time, out_byte);
        end else begin
          want = owed_bytes.pop_front();
          if (out_byte !== want.data) note_mismatch("out_byte", want.data, out_byte);
          if (is_header !== want.header)
            note_mismatch("is_header", 8'(want.header), 8'(is_header));
          if (packet_end !== want.pkt_last)
            note_mismatch("packet_end", 8'(want.pkt_last), 8'(packet_end));
          if (run_last !== want.run_end)
            note_mismatch("run_last", 8'(want.run_end), 8'(run_last));
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_MAX_PAYLOAD:    max_payload_r = cfg_data[10:0];
          CFG_TIMESTAMP_STEP: ts_step_r     = cfg_data[15:0];
          CFG_BUFFER_LIMIT:   limit_r       = cfg_data[23:0];
          CFG_PAYLOAD_TYPE:   pt_r          = cfg_data[6:0];
          CFG_SOURCE_ID:      ssrc_r        = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        packetize(item_kind_t'(func), frame_bytes, buffered_level, payload_byte);
      end
    end
    mismatches <= mismatch_count;
    owed       <= owed_bytes.size();
  end

endmodule

// File: tb/vp8_rtp_packetizer_tb.sv
`timescale 1ns / 100ps

module vp8_rtp_packetizer_tb;
  import vp8rtp_pkg::*;
  import vp8rtp_tb_pkg::*;

  localparam int                 RANDOM_ITEMS     = 300;
  localparam int                 WATCHDOG_LIMIT   = 2000;
  // frame starts and ignored bytes give no output, so allow the block time to settle
  localparam int                 SETTLE_CYCLES    = 20;
  // index with no register behind it, writes there must change nothing
  localparam logic [2:0]         CFG_NO_REG       = 3'd7;
  localparam logic [20:0]        LONGEST_FRAME    = 21'h1FFFFF;
  // just over the payload cap, so the marker bit shows which size is in force
  localparam logic [20:0]        LONG_CHUNK_FRAME = 21'd1190;
  localparam logic signed [24:0] LEVEL_ERROR      = -25'sd1;
  localparam logic [23:0]        LEVEL_TOP        = 24'hFFFFFF;

  logic               clk            = 1'b0;
  logic               rst            = 1'b1;
  logic               cfg_valid      = 1'b0;
  logic               cfg_ready;
  logic [2:0]         cfg_index      = '0;
  logic [31:0]        cfg_data       = '0;
  logic               in_valid       = 1'b0;
  logic               in_ready;
  logic               func           = 1'b0;
  logic [20:0]        frame_bytes    = '0;
  logic signed [24:0] buffered_level = '0;
  logic [7:0]         payload_byte   = '0;
  logic               out_valid;
  logic               out_ready      = 1'b0;
  logic [7:0]         out_byte;
  logic               is_header;
  logic               packet_end;
  logic               run_last;

  int mismatches;
  int owed;

  // stimulus shaping
  bit          calm         = 1'b0;   // no idling on either side once set
  bit          long_pending = 1'b0;
  int          gap_pct      = 25;
  int          ready_hold   = 0;
  int          idle_cycles  = 0;
  int          item_count   = 0;
  int          phase        = 0;
  logic [10:0] cur_max      = MAX_PAYLOAD_RESET;
  logic [23:0] cur_limit    = BUFFER_LIMIT_RESET;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  vp8_rtp_packetizer DUT (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .func(func), .frame_bytes(frame_bytes),
    .buffered_level(buffered_level), .payload_byte(payload_byte),
    .out_valid(out_valid), .out_ready(out_ready), .out_byte(out_byte),
    .is_header(is_header), .packet_end(packet_end), .run_last(run_last)
  );

  vp8_rtp_stream_check stream_check (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .func(func), .frame_bytes(frame_bytes),
    .buffered_level(buffered_level), .payload_byte(payload_byte),
    .out_valid(out_valid), .out_ready(out_ready), .out_byte(out_byte),
    .is_header(is_header), .packet_end(packet_end), .run_last(run_last),
    .mismatches(mismatches), .owed(owed)
  );

  // receiver: low bursts between high stretches, both of random length
  always @(posedge clk) begin
    if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else if (!out_ready || calm) begin
      out_ready  <= 1'b1;
      ready_hold <= calm ? 0 : $urandom_range(0, 40);
    end else begin
      out_ready  <= 1'b0;
      ready_hold <= $urandom_range(0, 10);
    end
  end

  // watchdog: ends the run when no transfer happens on any channel for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // one input transfer, optionally preceded by a burst of idle cycles on the sender side
  task automatic send_item(input item_kind_t kind, input logic [20:0] len,
                           input logic signed [24:0] lvl, input logic [7:0] data);
    if (!calm && ($urandom_range(0, 99) < gap_pct)) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    func           <= kind;
    frame_bytes    <= len;
    buffered_level <= lvl;
    payload_byte   <= data;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // fields that an item does not use still carry random values
  task automatic start_frame(input logic [20:0] len, input logic signed [24:0] lvl);
    send_item(FRAME_OPEN, len, lvl, 8'($urandom));
  endtask

  task automatic send_byte(input logic [7:0] data);
    send_item(PAYLOAD_BYTE, 21'($urandom), 25'($urandom), data);
  endtask

  // caller lowers cfg_valid after the last write of a group
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_MAX_PAYLOAD:  cur_max   = data[10:0];
      CFG_BUFFER_LIMIT: cur_limit = data[23:0];
      default: ;
    endcase
  endtask

  // stop sending, wait for every owed byte, then let the block settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (owed != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // buffer level: mostly within the limit, with the boundary, just above it and errors
  function automatic logic signed [24:0] pick_level();
    case ($urandom_range(0, 15))
      0:       return {1'b1, 24'($urandom)};
      1:       return {1'b0, cur_limit};
      2:       return (cur_limit == LEVEL_TOP) ? LEVEL_ERROR : {1'b0, cur_limit + 24'd1};
      3:       return {1'b0, 24'($urandom)};
      default: return {1'b0, 24'($urandom_range(0, cur_limit))};
    endcase
  endfunction

  task automatic configure_phase(input int n);
    case (n)
      1: begin
        // every register at its top, payload size above the cap
        write_reg(CFG_MAX_PAYLOAD, 32'd2047);
        write_reg(CFG_TIMESTAMP_STEP, 32'hFFFF);
        write_reg(CFG_BUFFER_LIMIT, 32'hFFFFFF);
        write_reg(CFG_PAYLOAD_TYPE, 32'h7F);
        write_reg(CFG_SOURCE_ID, 32'hFFFFFFFF);
        long_pending = 1'b1;
      end
      2: begin
        // every register at zero, payload size zero behaves as one
        write_reg(CFG_MAX_PAYLOAD, '0);
        write_reg(CFG_TIMESTAMP_STEP, '0);
        write_reg(CFG_BUFFER_LIMIT, '0);
        write_reg(CFG_PAYLOAD_TYPE, '0);
        write_reg(CFG_SOURCE_ID, '0);
      end
      3: begin
        write_reg(CFG_MAX_PAYLOAD, 32'(PAYLOAD_CAP));
        write_reg(CFG_BUFFER_LIMIT, 32'($urandom_range(24'h400000, 24'hFFFFFF)));
      end
      default: begin
        // small packets mostly, so chunk boundaries come often; upper data bits random
        if ($urandom_range(0, 1) == 1) begin
          write_reg(CFG_MAX_PAYLOAD, {21'($urandom), ($urandom_range(0, 4) == 0) ?
                                      11'($urandom) : 11'($urandom_range(1, 12))});
        end
        if ($urandom_range(0, 1) == 1) write_reg(CFG_TIMESTAMP_STEP, $urandom);
        if ($urandom_range(0, 2) == 0) write_reg(CFG_BUFFER_LIMIT, $urandom);
        if ($urandom_range(0, 1) == 1) write_reg(CFG_PAYLOAD_TYPE, $urandom);
        if ($urandom_range(0, 1) == 1) write_reg(CFG_SOURCE_ID, $urandom);
      end
    endcase
    cfg_valid <= 1'b0;
  endtask

  // one frame: mostly complete with random content, sometimes empty, dropped,
  // oversized or cut short, with the odd stray byte in front
  task automatic random_frame();
    logic [20:0]        len;
    logic signed [24:0] lvl;
    bit                 dropped;
    bit                 long_one;
    int                 span;
    int                 sent;
    span         = (cur_max == '0) ? 3 : ((3 * cur_max < 40) ? 3 * cur_max : 40);
    long_one     = long_pending;
    long_pending = 1'b0;
    if ($urandom_range(0, 9) == 0) send_byte(8'($urandom));
    case ($urandom_range(0, 19))
      0:       len = '0;
      1:       len = ($urandom_range(0, 1) == 1) ? LONGEST_FRAME : 21'($urandom);
      default: len = 21'($urandom_range(1, span));
    endcase
    lvl = pick_level();
    if (long_one) begin
      len = LONG_CHUNK_FRAME;
      lvl = {1'b0, 24'($urandom_range(0, cur_limit))};
    end
    dropped = lvl[24] || (lvl[23:0] > cur_limit) || (len == '0);
    start_frame(len, lvl);
    if (dropped) sent = $urandom_range(0, 3);
    else if (len > 40) sent = $urandom_range(1, 20);
    else if ($urandom_range(0, 7) == 0) sent = $urandom_range(0, len - 1);
    else sent = len;
    repeat (sent) send_byte(8'($urandom));
    // bytes of dropped frames are ignored
    if (!dropped) item_count += sent + 1;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // reset settings: stray byte, empty frame, error level, level above the limit,
    // then a two-byte frame with the level exactly at the limit
    send_byte(8'hFF);
    start_frame('0, '0);
    start_frame(21'd3, LEVEL_ERROR);
    send_byte(8'hA5);
    start_frame(LONGEST_FRAME, {1'b0, LEVEL_TOP});
    start_frame(21'd2, {1'b0, BUFFER_LIMIT_RESET});
    send_byte(8'h00);
    send_byte(8'hFF);
    wait_idle();

    // registers at their top, payload size zero acting as one
    write_reg(CFG_MAX_PAYLOAD, '0);
    write_reg(CFG_TIMESTAMP_STEP, 32'hFFFF);
    write_reg(CFG_BUFFER_LIMIT, 32'hFFFFFF);
    write_reg(CFG_PAYLOAD_TYPE, 32'h7F);
    write_reg(CFG_SOURCE_ID, 32'hFFFFFFFF);
    write_reg(CFG_NO_REG, 32'hFFFFFFFF);
    cfg_valid <= 1'b0;
    // largest frame at the highest level, abandoned after two packets by a new start
    start_frame(LONGEST_FRAME, {1'b0, LEVEL_TOP});
    send_byte(8'h5A);
    send_byte(8'hC3);
    start_frame(21'd3, '0);
    repeat (3) send_byte(8'($urandom));
    wait_idle();

    // zero limit drops any positive level; three bytes of a five-byte frame, chunks of two
    write_reg(CFG_MAX_PAYLOAD, 32'd2);
    write_reg(CFG_TIMESTAMP_STEP, '0);
    write_reg(CFG_BUFFER_LIMIT, '0);
    write_reg(CFG_PAYLOAD_TYPE, '0);
    write_reg(CFG_SOURCE_ID, '0);
    cfg_valid <= 1'b0;
    start_frame(21'd3, 25'sd1);
    start_frame(21'd5, '0);
    repeat (3) send_byte(8'($urandom));
    wait_idle();

    // payload size lowered with a packet half full: it ends on the next byte
    write_reg(CFG_MAX_PAYLOAD, 32'd1);
    cfg_valid <= 1'b0;
    repeat (2) send_byte(8'($urandom));
    wait_idle();

    // random phases, each with its own settings and sender idling rate; frames may
    // stay open across a phase boundary, so settings also change mid-packet
    while (item_count < RANDOM_ITEMS) begin
      phase++;
      case ($urandom_range(0, 3))
        0:       gap_pct = 0;
        1:       gap_pct = 5;
        2:       gap_pct = 25;
        default: gap_pct = 50;
      endcase
      configure_phase(phase);
      repeat ($urandom_range(3, 8)) begin
        calm = (item_count >= RANDOM_ITEMS * 4 / 5);
        random_frame();
      end
      wait_idle();
    end

    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
